// ===== rtl/core/bbt_pkg.sv =====
package bbt_pkg;

  // Field and register widths
  localparam int ROW_W    = 16;
  localparam int ROW_IW   = 4;
  localparam int SIZE_W   = 5;
  localparam int MODE_W   = 3;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 6;
  localparam int OUT_W    = 64;
  localparam int OSIDE_W  = 7;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 8;

  localparam int DEF_MAX_SIZE = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IW-1:0] REG_IMAGE_SIZE     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_TRANSFORM_MODE = 2'd1;

  localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE = 5'd16;
  localparam logic [MODE_W-1:0] RST_MODE       = 3'd0;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SYM   = 2'd2
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ROT      = 3'd0,
    MODE_MIRROR_H = 3'd1,
    MODE_MIRROR_V = 3'd2,
    MODE_UP2      = 3'd3,
    MODE_UP4      = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic write;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/bbt_ifs.sv =====
interface bbt_in_if;
  import bbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] row_index;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output operation, output row_index, output row_bits,
                  input ready);
  modport sink   (input valid, input operation, input row_index, input row_bits,
                  output ready);
endinterface

interface bbt_out_if;
  import bbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] row_out;
  logic             symmetric;
  logic             index_error;

  modport source (output valid, output row_out, output symmetric, output index_error,
                  input ready);
  modport sink   (input valid, input row_out, input symmetric, input index_error,
                  output ready);
endinterface

interface bbt_cfg_if;
  import bbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/bbt_ram.sv =====
module bbt_ram #(
  parameter int WIDTH = bbt_pkg::ROW_W,
  parameter int DEPTH = bbt_pkg::DEF_MAX_SIZE
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/core/bbt_ctrl.sv =====
module bbt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbt_pkg::stat_t stat,
  output bbt_pkg::cmd_t  cmd
);
  import bbt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.scan_start = 1'b1;
        if (stat.need_scan) begin
          state_nxt = S_READ;
        end else begin
          cmd.write = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_WAIT;
        end
      end
      // last row still on its way out of the memory
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execution");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && stat.scan_last) |=> (state_r == S_WAIT))
    else $error("scan overran its last row");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (state_r == S_IDLE && in_ready))
    else $error("controller not idle after result transfer");

endmodule

// ===== rtl/core/bbt_datapath.sv =====
module bbt_datapath #(
  parameter int MAX_SIZE = bbt_pkg::DEF_MAX_SIZE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbt_pkg::in_item_t in_item,
  input  bbt_pkg::cmd_t     cmd,
  output bbt_pkg::stat_t    stat,
  bbt_cfg_if.sink           cfg_ch,
  bbt_out_if.source         out_ch
);
  import bbt_pkg::*;

  localparam int AW = $clog2(MAX_SIZE);

  logic [SIZE_W-1:0]  image_size_r;
  logic [MODE_W-1:0]  mode_r;
  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ROW_W-1:0]   bits_r;
  logic [AW-1:0]      cnt_r;
  logic               rdv_r;
  logic [AW-1:0]      rdk_r;
  logic [ROW_W-1:0]   row_r;
  logic [ROW_W-1:0]   cap_r [MAX_SIZE];
  logic               out_valid_r;
  logic [OUT_W-1:0]   row_out_r;
  logic               sym_out_r;
  logic               err_out_r;

  logic [SIZE_W-1:0]  n;
  logic [OSIDE_W-1:0] oside;
  logic               mode_ok;
  logic               err;
  logic               read_go;
  logic               rot_scan;
  logic               sym_scan;
  logic [AW-1:0]      last_cnt;
  logic [SIZE_W-1:0]  flip_idx;
  logic [SIZE_W-1:0]  rot_pos;
  logic [AW-1:0]      rd_addr;
  logic [ROW_W-1:0]   rd_data;
  logic               ram_we;
  logic [ROW_W-1:0]   col_mask;
  logic [ROW_W-1:0]   row_m;
  logic [ROW_W-1:0]   row_rev;
  logic [ROW_W-1:0]   mirror;
  logic [2*ROW_W-1:0] up2;
  logic [4*ROW_W-1:0] up4;
  logic [OUT_W-1:0]   row_res;
  logic               asym;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_size_r <= RST_IMAGE_SIZE;
      mode_r       <= RST_MODE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_IMAGE_SIZE:     image_size_r <= cfg_ch.data[SIZE_W-1:0];
        REG_TRANSFORM_MODE: mode_r       <= cfg_ch.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the side length into 1..MAX_SIZE
  always_comb begin
    if (image_size_r == '0) begin
      n = SIZE_W'(1);
    end else if (image_size_r > SIZE_W'(MAX_SIZE)) begin
      n = SIZE_W'(MAX_SIZE);
    end else begin
      n = image_size_r;
    end
  end

  always_comb begin
    unique case (mode_r)
      MODE_UP2: oside = OSIDE_W'({n, 1'b0});
      MODE_UP4: oside = OSIDE_W'({n, 2'b00});
      default:  oside = OSIDE_W'(n);
    endcase
  end

  assign mode_ok = (mode_r <= MODE_UP4);

  always_comb begin
    err = 1'b0;
    if (op_r == OP_WRITE) begin
      err = (idx_r >= IDX_W'(n));
    end else if (op_r == OP_READ) begin
      err = mode_ok && (OSIDE_W'(idx_r) >= oside);
    end
  end

  assign read_go  = (op_r == OP_READ) && mode_ok && !err;
  assign rot_scan = read_go && (mode_r == MODE_ROT);
  assign sym_scan = (op_r == OP_SYM);
  assign last_cnt = (rot_scan || sym_scan) ? AW'(n - SIZE_W'(1)) : '0;

  assign stat.need_scan = read_go || sym_scan;
  assign stat.scan_last = (cnt_r == last_cnt);
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  // Hold the item for the length of its work
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_item.operation;
      idx_r  <= in_item.row_index;
      bits_r <= in_item.row_bits;
    end
  end

  // Row address counter and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.scan_step;
      if (cmd.scan_start) begin
        cnt_r <= '0;
      end else if (cmd.scan_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdk_r <= cnt_r;
  end

  assign flip_idx = n - SIZE_W'(1) - idx_r[SIZE_W-1:0];

  always_comb begin
    rd_addr = cnt_r;
    if (!(rot_scan || sym_scan)) begin
      unique case (mode_r)
        MODE_MIRROR_H: rd_addr = idx_r[AW-1:0];
        MODE_MIRROR_V: rd_addr = flip_idx[AW-1:0];
        MODE_UP2:      rd_addr = AW'(idx_r >> 1);
        MODE_UP4:      rd_addr = AW'(idx_r >> 2);
        default:       rd_addr = cnt_r;
      endcase
    end
  end

  assign ram_we = cmd.write && (op_r == OP_WRITE) && !err;

  bbt_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (bits_r),
    .re    (cmd.scan_step),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Gather: rotation collects one bit per row, other reads keep the row
  assign rot_pos = n - SIZE_W'(1) - SIZE_W'(rdk_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= '0;
    end else if (rdv_r) begin
      if (rot_scan) begin
        row_r[rot_pos[ROW_IW-1:0]] <= rd_data[idx_r[ROW_IW-1:0]];
      end else begin
        row_r <= rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdv_r) begin
      cap_r[rdk_r] <= rd_data;
    end
  end

  // Result formation
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      col_mask[j] = (j < int'(n));
      row_rev[j]  = row_r[ROW_W-1-j];
    end
  end

  assign row_m  = row_r & col_mask;
  assign mirror = row_rev >> (SIZE_W'(ROW_W) - n);

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      up2[2*j +: 2] = {2{row_m[j]}};
      up4[4*j +: 4] = {4{row_m[j]}};
    end
  end

  always_comb begin
    row_res = '0;
    if (read_go) begin
      unique case (mode_r)
        MODE_ROT:      row_res = OUT_W'(row_r);
        MODE_MIRROR_H: row_res = OUT_W'(mirror);
        MODE_MIRROR_V: row_res = OUT_W'(row_m);
        MODE_UP2:      row_res = OUT_W'(up2);
        MODE_UP4:      row_res = OUT_W'(up4);
        default:       row_res = '0;
      endcase
    end
  end

  always_comb begin
    asym = 1'b0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      for (int j = i + 1; j < MAX_SIZE; j++) begin
        if ((j < int'(n)) && (cap_r[i][j] != cap_r[j][i])) begin
          asym = 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      row_out_r <= row_res;
      sym_out_r <= sym_scan && !asym;
      err_out_r <= err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_out     = row_out_r;
  assign out_ch.symmetric   = sym_out_r;
  assign out_ch.index_error = err_out_r;

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> stat.out_free)
    else $error("result overwrote one not yet taken");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rdv_r |-> (rdk_r <= last_cnt))
    else $error("row read beyond the scan length");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!cmd.scan_step && !rdv_r))
    else $error("row write during a scan");

endmodule

// ===== rtl/core/binary_bitmap_transform.sv =====
// Square one-bit bitmap of side image_size (1..MAX_SIZE, 0 acts as 1, larger acts as
// MAX_SIZE), stored one 16-bit row per entry in a single-port-read row memory. Items
// are taken one at a time; a result waits in an output register, so the next item is
// taken while the previous result is still waiting for transfer. A row write, and any
// item that reads no row (an out-of-range read, a read in an unused mode, the spare
// operation), reads nothing from the memory; a mirrored or upscaled row read reads one
// row, and a rotated row read or a symmetry check reads all n rows, n being the side
// length, one row per cycle through the memory's read port. Hand-off waits while the
// output register holds an untaken result. Rows hold no defined value until written and
// there is no clearing pass; a rotation or symmetry check must only follow writes of
// all n rows. Out-of-range row indexes raise index_error and leave the memory alone.
module binary_bitmap_transform #(
  parameter int MAX_SIZE = bbt_pkg::DEF_MAX_SIZE
) (
  input logic       clk,
  input logic       rst_n,
  bbt_in_if.sink    in_ch,
  bbt_out_if.source out_ch,
  bbt_cfg_if.sink   cfg_ch
);
  import bbt_pkg::*;

  cmd_t     cmd;
  stat_t    stat;
  in_item_t in_item;
  logic     in_ready;

  // Ready only while the controller is idle
  assign in_ch.ready = in_ready;

  assign in_item.operation = in_ch.operation;
  assign in_item.row_index = in_ch.row_index;
  assign in_item.row_bits  = in_ch.row_bits;

  // Sequence capture, row scan and result hand-off
  bbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold configuration, row memory, gathering and the output register
  bbt_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .stat    (stat),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/sv/binary_bitmap_transform_test.sv =====
module binary_bitmap_transform_test;
  import bbt_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int MAX_SIDE      = DEF_MAX_SIZE;
  localparam int NUM_PHASES    = 24;
  localparam int PLANNED       = 12;
  localparam int PHASE_ITEMS   = 68;
  localparam int STALL_PHASE   = 17;
  localparam int LONG_STALL    = 400;
  // Longest item is a rotation or symmetry scan; add margin
  localparam int SETTLE_CYCLES = MAX_SIDE + 12;
  localparam int LIMIT_CYCLES  = 600000;

  // Codes the block has no name for: the spare operation and the unused modes
  localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RSV5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSV6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSV7 = 3'd7;

  typedef struct packed {
    logic [OUT_W-1:0] row_out;
    logic             symmetric;
    logic             index_error;
  } result_t;

  logic clk;
  logic rst_n;

  bbt_in_if  in_ch ();
  bbt_out_if out_ch ();
  bbt_cfg_if cfg_ch ();

  binary_bitmap_transform uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: a copy of the bitmap and both registers
  logic [ROW_W-1:0]  shadow_rows [MAX_SIDE];
  logic [SIZE_W-1:0] shadow_size;
  logic [MODE_W-1:0] shadow_mode;

  // Items waiting for the driver, and results waiting for the block
  in_item_t pending_items [$];
  result_t  expected_results [$];

  // Stimulus-side view: which rows hold data, and the setting in force
  logic [MAX_SIDE-1:0] gen_written = '0;
  int                  gen_side = MAX_SIDE;
  logic [MODE_W-1:0]   gen_mode = RST_MODE;

  int unsigned in_idle_pct  = 28;
  int unsigned out_idle_pct = 79;

  // Long receiver hold-off, counted in its own process
  logic        stall_kick = 1'b0;
  logic        stall_seen;
  int unsigned stall_left;

  int error_count    = 0;
  int items_in       = 0;
  int results_seen   = 0;
  int row_reads      = 0;
  int symmetric_hits = 0;
  int index_errors   = 0;
  int queued_total   = 0;

  logic [SIZE_W-1:0] plan_size [PLANNED] = '{
    5'd1, 5'd16, 5'd0, 5'd31, 5'd16, 5'd2, 5'd5, 5'd16, 5'd7, 5'd1, 5'd9, 5'd16
  };
  logic [MODE_W-1:0] plan_mode [PLANNED] = '{
    MODE_ROT, MODE_MIRROR_H, MODE_UP2, MODE_UP4, MODE_UP4, MODE_MIRROR_V,
    MODE_RSV5, MODE_UP2, MODE_RSV7, MODE_UP4, MODE_RSV6, MODE_ROT
  };

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Side length in force: zero acts as one, anything above the maximum clamps
  function automatic int side_of(logic [SIZE_W-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_SIDE) return MAX_SIDE;
    return int'(size);
  endfunction

  // Number of output rows (and columns) for a given mode
  function automatic int out_side(int n, logic [MODE_W-1:0] mode);
    case (mode)
      MODE_UP2: return 2 * n;
      MODE_UP4: return 4 * n;
      default:  return n;
    endcase
  endfunction

  function automatic logic [OUT_W-1:0] transformed_row(int n, int r);
    logic [OUT_W-1:0] acc;
    int k;
    acc = '0;
    k = (shadow_mode == MODE_UP2) ? 2 : 4;
    case (shadow_mode)
      MODE_ROT:      for (int j = 0; j < n; j++) acc[j] = shadow_rows[n-1-j][r];
      MODE_MIRROR_H: for (int j = 0; j < n; j++) acc[j] = shadow_rows[r][n-1-j];
      MODE_MIRROR_V: for (int j = 0; j < n; j++) acc[j] = shadow_rows[n-1-r][j];
      MODE_UP2, MODE_UP4: begin
        for (int j = 0; j < n * k; j++) acc[j] = shadow_rows[r/k][j/k];
      end
      default: ;
    endcase
    return acc;
  endfunction

  // Only the n x n corner counts; columns at or above n are ignored
  function automatic logic transpose_equal(int n);
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (shadow_rows[i][j] != shadow_rows[j][i]) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the shadow bitmap by one item and return the result it must give
  function automatic result_t apply_item(in_item_t item);
    result_t res;
    int n;
    int idx;
    res = '0;
    n = side_of(shadow_size);
    idx = int'(item.row_index);
    case (item.operation)
      OP_WRITE: begin
        if (idx < n) shadow_rows[idx] = item.row_bits;
        else res.index_error = 1'b1;
      end
      OP_READ: begin
        // Unused modes answer zero with no error
        if (shadow_mode <= MODE_UP4) begin
          if (idx < out_side(n, shadow_mode)) res.row_out = transformed_row(n, idx);
          else res.index_error = 1'b1;
        end
      end
      OP_SYM: res.symmetric = transpose_equal(n);
      default: ;
    endcase
    return res;
  endfunction

  // Track register writes as the block sees them
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_size <= RST_IMAGE_SIZE;
      shadow_mode <= RST_MODE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_IMAGE_SIZE:     shadow_size <= cfg_ch.data[SIZE_W-1:0];
        REG_TRANSFORM_MODE: shadow_mode <= cfg_ch.data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: predict on every input transfer, then offer the next pending item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_item_t taken;
    in_item_t next_item;
    result_t  predicted;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      foreach (shadow_rows[r]) shadow_rows[r] = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.operation = in_ch.operation;
        taken.row_index = in_ch.row_index;
        taken.row_bits  = in_ch.row_bits;
        predicted = apply_item(taken);
        expected_results.push_back(predicted);
        items_in++;
        if (taken.operation == OP_READ && shadow_mode <= MODE_UP4 && !predicted.index_error)
          row_reads++;
        if (predicted.symmetric) symmetric_hits++;
        if (predicted.index_error) index_errors++;
      end
      // Hold the current item until it is taken; otherwise load the next or idle
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99, 0) >= in_idle_pct) begin
          next_item = pending_items.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.operation <= next_item.operation;
          in_ch.row_index <= next_item.row_index;
          in_ch.row_bits  <= next_item.row_bits;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every result transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing outstanding: row_out %h symmetric %b error %b",
                 out_ch.row_out, out_ch.symmetric, out_ch.index_error);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.row_out !== want.row_out) begin
            $error("row_out: expected %h, got %h", want.row_out, out_ch.row_out);
            error_count++;
          end
          if (out_ch.symmetric !== want.symmetric) begin
            $error("symmetric: expected %b, got %b", want.symmetric, out_ch.symmetric);
            error_count++;
          end
          if (out_ch.index_error !== want.index_error) begin
            $error("index_error: expected %b, got %b", want.index_error, out_ch.index_error);
            error_count++;
          end
        end
      end
      out_ch.ready <= (stall_left == 0) && ($urandom_range(99, 0) >= out_idle_pct);
    end
  end

  // Start a long hold-off each time the kick toggles, then count it down
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_seen <= 1'b0;
      stall_left <= 0;
    end else if (stall_kick != stall_seen) begin
      stall_seen <= stall_kick;
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_item(input logic [OP_W-1:0] op, input int idx,
                            input logic [ROW_W-1:0] bits);
    in_item_t item;
    item.operation = op;
    item.row_index = idx[IDX_W-1:0];
    item.row_bits  = bits;
    if (op == OP_WRITE && idx < gen_side) gen_written[idx] = 1'b1;
    pending_items.push_back(item);
    queued_total++;
  endtask

  // First row that this item would read but that has never been written, or -1
  function automatic int missing_row(logic [OP_W-1:0] op, int idx);
    logic [MAX_SIDE-1:0] need;
    need = '0;
    if (op == OP_SYM) begin
      need = MAX_SIDE'((1 << gen_side) - 1);
    end else if (op == OP_READ && gen_mode <= MODE_UP4
                 && idx < out_side(gen_side, gen_mode)) begin
      case (gen_mode)
        MODE_ROT:      need = MAX_SIDE'((1 << gen_side) - 1);
        MODE_MIRROR_H: need[idx] = 1'b1;
        MODE_MIRROR_V: need[gen_side-1-idx] = 1'b1;
        MODE_UP2:      need[idx/2] = 1'b1;
        default:       need[idx/4] = 1'b1;
      endcase
    end
    for (int r = 0; r < MAX_SIDE; r++)
      if (need[r] && !gen_written[r]) return r;
    return -1;
  endfunction

  // Never let a read touch an unwritten row: write that row first instead
  task automatic queue_safe(input logic [OP_W-1:0] op, input int idx,
                            input logic [ROW_W-1:0] bits);
    int gap;
    gap = missing_row(op, idx);
    if (gap >= 0) queue_item(OP_WRITE, gap, ROW_W'($urandom_range(16'hFFFF, 0)));
    else queue_item(op, idx, bits);
  endtask

  // Write a fresh image in shuffled row order, optionally symmetric about the diagonal
  task automatic load_image(input bit diag_mirror);
    logic [ROW_W-1:0] img [MAX_SIDE];
    int order [MAX_SIDE];
    int pick;
    int tmp;
    for (int r = 0; r < gen_side; r++) begin
      img[r] = ROW_W'($urandom_range(16'hFFFF, 0));
      order[r] = r;
    end
    if (diag_mirror)
      for (int i = 0; i < gen_side; i++)
        for (int j = 0; j < i; j++) img[i][j] = img[j][i];
    for (int r = gen_side - 1; r > 0; r--) begin
      pick = $urandom_range(r, 0);
      tmp = order[r];
      order[r] = order[pick];
      order[pick] = tmp;
    end
    for (int r = 0; r < gen_side; r++) queue_item(OP_WRITE, order[r], img[order[r]]);
  endtask

  task automatic random_item();
    int roll;
    int osz;
    int idx;
    roll = $urandom_range(99, 0);
    osz = out_side(gen_side, gen_mode);
    if (roll < 22) begin
      idx = ($urandom_range(99, 0) < 85) ? $urandom_range(gen_side - 1, 0)
                                         : $urandom_range(63, 0);
      queue_safe(OP_WRITE, idx, ROW_W'($urandom_range(16'hFFFF, 0)));
    end else if (roll < 67) begin
      if (osz < 64 && $urandom_range(99, 0) < 15) idx = $urandom_range(63, osz);
      else idx = $urandom_range(osz - 1, 0);
      queue_safe(OP_READ, idx, ROW_W'($urandom_range(16'hFFFF, 0)));
    end else if (roll < 87) begin
      queue_safe(OP_SYM, $urandom_range(63, 0), ROW_W'($urandom_range(16'hFFFF, 0)));
    end else if (roll < 95) begin
      queue_safe(OP_NONE, $urandom_range(63, 0), ROW_W'($urandom_range(16'hFFFF, 0)));
    end else begin
      queue_safe(OP_WRITE, $urandom_range(63, gen_side),
                 ROW_W'($urandom_range(16'hFFFF, 0)));
    end
  endtask

  // Drive one register write and hold it until the block takes it
  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic wait_quiet();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [SIZE_W-1:0] size_val;
    logic [MODE_W-1:0] mode_val;
    logic [MAX_SIDE-1:0] side_mask;
    int phase_start;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_WRITE;
    in_ch.row_index = '0;
    in_ch.row_bits  = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_IMAGE_SIZE;
    cfg_ch.data     = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset setting: full-size rotation
    queue_item(OP_NONE, 63, 16'hFFFF);
    queue_item(OP_WRITE, MAX_SIDE, 16'hFFFF);
    queue_item(OP_WRITE, 63, 16'h0000);
    for (int r = 0; r < MAX_SIDE; r++)
      queue_item(OP_WRITE, r, (r == 0) ? 16'h0000 :
                              (r == MAX_SIDE - 1) ? 16'hFFFF :
                              ROW_W'($urandom_range(16'hFFFF, 0)));
    queue_item(OP_READ, 0, 16'h0000);
    queue_item(OP_READ, MAX_SIDE - 1, 16'hFFFF);
    queue_item(OP_READ, MAX_SIDE, 16'h0000);
    queue_item(OP_READ, 63, 16'h0000);
    queue_item(OP_SYM, 0, 16'h0000);
    wait_quiet();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Sender idles lightly and receiver heavily, then the reverse, then neither
      if (p < 8) begin
        in_idle_pct  = 28;
        out_idle_pct = 79;
      end else if (p < 16) begin
        in_idle_pct  = 79;
        out_idle_pct = 28;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      if (p < PLANNED) begin
        size_val = plan_size[p];
        mode_val = plan_mode[p];
      end else begin
        size_val = SIZE_W'($urandom_range(31, 0));
        mode_val = MODE_W'($urandom_range(7, 0));
      end
      // Upper data bits are don't-care; toggle them anyway
      cfg_write(REG_IMAGE_SIZE, {3'($urandom_range(7, 0)), size_val});
      cfg_write(REG_TRANSFORM_MODE, {5'($urandom_range(31, 0)), mode_val});
      gen_side = side_of(size_val);
      gen_mode = mode_val;
      @(negedge clk);

      // Stall the receiver while the sender keeps offering, so the block backs up
      if (p == STALL_PHASE) stall_kick = ~stall_kick;

      phase_start = queued_total;
      side_mask = MAX_SIDE'((1 << gen_side) - 1);
      // Sometimes keep rows from earlier settings to check they survive a size change
      if ((gen_written & side_mask) != side_mask || $urandom_range(2, 0) != 0)
        load_image($urandom_range(9, 0) < 4);
      queue_safe(OP_SYM, 0, 16'h0000);
      queue_safe(OP_READ, 0, 16'h0000);
      queue_safe(OP_READ, out_side(gen_side, gen_mode) - 1, 16'h0000);
      while (queued_total - phase_start < PHASE_ITEMS) random_item();
      wait_quiet();
    end

    $display("binary_bitmap_transform_test: %0d items sent, %0d results checked, %0d settings",
             items_in, results_seen, NUM_PHASES + 1);
    $display("  %0d row reads, %0d symmetric images, %0d index errors, %0d-cycle hold-off",
             row_reads, symmetric_hits, index_errors, LONG_STALL);
    if (error_count == 0) begin
      $display("[binary_bitmap_transform] OK");
    end else begin
      $display("[binary_bitmap_transform] ERROR");
    end
    $finish;
  end

  // Watchdog: end a run that has hung
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[binary_bitmap_transform] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bbt_pkg.sv
rtl/core/bbt_ifs.sv
rtl/core/bbt_ram.sv
rtl/core/bbt_ctrl.sv
rtl/core/bbt_datapath.sv
rtl/core/binary_bitmap_transform.sv
tb/sv/binary_bitmap_transform_test.sv
